// ===== hw/rtl/area_image_resize_defines.svh =====
// Assertion macros used by the checker file of the image resizer.
`ifndef AREA_IMAGE_RESIZE_DEFINES_SVH
`define AREA_IMAGE_RESIZE_DEFINES_SVH

// Implication in the same cycle, switched off while reset is asserted.
`define AIR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication into the next cycle, switched off while reset is asserted.
`define AIR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Implication into the next cycle that also holds across reset.
`define AIR_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/air_pkg.sv =====
// Shared constants of the area and bilinear image resizer.
package air_pkg;

  localparam int CFG_W    = 9;
  localparam int IDX_W    = 3;
  localparam int CC_W     = 3;
  localparam int CH_W     = 8;
  localparam int CH_COUNT = 4;
  localparam int PIX_W    = CH_W * CH_COUNT;

  localparam logic [IDX_W-1:0] REG_SRC_W    = 3'd0;
  localparam logic [IDX_W-1:0] REG_SRC_H    = 3'd1;
  localparam logic [IDX_W-1:0] REG_DST_W    = 3'd2;
  localparam logic [IDX_W-1:0] REG_DST_H    = 3'd3;
  localparam logic [IDX_W-1:0] REG_CHANNELS = 3'd4;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_FETCH = 1'b1;

  localparam int RST_SIZE     = 256;
  localparam int RST_CHANNELS = 3;

  localparam int WBITS    = 11;
  localparam int WONE     = 1 << WBITS;
  localparam int WHALF    = WONE >> 1;
  localparam int BYTE_MAX = 255;

  localparam int NEIGHBOURS = 4;

  localparam int DEF_MAX_SRC_W = 256;
  localparam int DEF_MAX_SRC_H = 256;
  localparam int DEF_MAX_DST_W = 256;
  localparam int DEF_MAX_DST_H = 256;

endpackage

// ===== hw/rtl/air_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module air_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/area_image_resize.sv =====
// Image resizer with a frame store. A load beat writes one source pixel of up to four
// channels in raster order. A fetch beat returns the next destination pixel. When neither
// axis grows the pixel is an exact area average, otherwise a bilinear blend with 11-bit
// weights. All divisions run on one shared restoring divider of NW steps (NW is 28 at the
// default sizes). A fetch first divides for the window origin on each axis. In area mode
// it then accumulates each source pixel in the window and divides once per channel in use.
// In bilinear mode it also divides for the weight on each axis, then does the four reads
// and the blend. The pixel then moves into the output register, where it waits while
// out_ready is low; in_ready is low until then.
// The store has no reset and must be loaded before it is fetched from.
module area_image_resize #(
  parameter int MAX_SRC_W = air_pkg::DEF_MAX_SRC_W,
  parameter int MAX_SRC_H = air_pkg::DEF_MAX_SRC_H,
  parameter int MAX_DST_W = air_pkg::DEF_MAX_DST_W,
  parameter int MAX_DST_H = air_pkg::DEF_MAX_DST_H
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_action,
  input  logic [air_pkg::CH_W-1:0]   in_ch0,
  input  logic [air_pkg::CH_W-1:0]   in_ch1,
  input  logic [air_pkg::CH_W-1:0]   in_ch2,
  input  logic [air_pkg::CH_W-1:0]   in_ch3,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [air_pkg::CH_W-1:0]   out_ch0,
  output logic [air_pkg::CH_W-1:0]   out_ch1,
  output logic [air_pkg::CH_W-1:0]   out_ch2,
  output logic [air_pkg::CH_W-1:0]   out_ch3,
  output logic                       out_frame_end,
  input  logic                       cfg_we,
  input  logic [air_pkg::IDX_W-1:0]  cfg_index,
  input  logic [air_pkg::CFG_W-1:0]  cfg_data
);

  import air_pkg::*;

  localparam int SWB   = $clog2(MAX_SRC_W + 1);
  localparam int SHB   = $clog2(MAX_SRC_H + 1);
  localparam int DWB   = $clog2(MAX_DST_W + 1);
  localparam int DHB   = $clog2(MAX_DST_H + 1);
  localparam int SB    = (SWB > SHB) ? SWB : SHB;
  localparam int DB    = (DWB > DHB) ? DWB : DHB;
  localparam int DXI   = $clog2(MAX_DST_W);
  localparam int DYI   = $clog2(MAX_DST_H);
  localparam int DEPTH = MAX_SRC_W * MAX_SRC_H;
  localparam int AW    = $clog2(DEPTH);
  localparam int TB    = SWB + SHB;
  localparam int PW    = SB + DB;
  localparam int AB    = TB + CH_W;
  localparam int FW    = ((SB > DB) ? SB : DB) + 1;
  localparam int WB    = WBITS + 1;
  localparam int LW    = WBITS + CH_W + 2;
  localparam int NW0   = (PW > SB + WBITS + 1) ? PW : SB + WBITS + 1;
  localparam int NW    = (NW0 > AB + 2) ? NW0 : AB + 2;
  localparam int DVW   = (DB > TB + 1) ? DB : TB + 1;
  localparam int CNTW  = $clog2(NW + 1);
  localparam int KW    = $clog2(NEIGHBOURS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_AQ, S_AR, S_AW, S_DIV, S_PA, S_PB, S_FQ, S_FR, S_BRD, S_BT, S_BV, S_PUT
  } state_t;

  state_t             state_r, ret_r;
  logic [CFG_W-1:0]   src_w_r, src_h_r, dst_w_r, dst_h_r;
  logic [CC_W-1:0]    cc_r;
  logic [AW-1:0]      lpos_r;
  logic [DXI-1:0]     col_r;
  logic [DYI-1:0]     row_r;
  logic [DB-1:0]      dx_r, dy_r;
  logic               fe_r, ax_r;
  logic [SB-1:0]      base_x_r, base_y_r;
  logic [WB-1:0]      w1_x_r, w1_y_r;
  logic [PW-1:0]      lo_x_r, lo_y_r, sl0_x_r, sxl_r, syl_r;
  logic [SB-1:0]      sx_r, sy_r;
  logic [2*DB-1:0]    weight_r;
  logic [AB-1:0]      acc_r [CH_COUNT];
  logic [1:0]         ch_r;
  logic [KW-1:0]      k_r;
  logic [PIX_W-1:0]   p_r [NEIGHBOURS];
  logic [CH_W-1:0]    t0_r [CH_COUNT];
  logic [CH_W-1:0]    t1_r [CH_COUNT];
  logic [CH_W-1:0]    res_r [CH_COUNT];
  logic [CH_W-1:0]    out_r [CH_COUNT];
  logic               out_fe_r, out_valid_r;
  logic [NW-1:0]      div_num_r;
  logic [DVW-1:0]     div_den_r, div_rem_r;
  logic [CNTW-1:0]    div_cnt_r;

  logic [SB-1:0]      sw_c, sh_c;
  logic [DB-1:0]      dw_c, dh_c;
  logic [CC_W-1:0]    cc_c;
  logic [TB-1:0]      total_c;
  logic               area_mode;
  logic [DB-1:0]      d_ax, dn_ax;
  logic [SB-1:0]      sn_ax, base_ax, q_s, nx, ny, row_sel, col_sel;
  logic [PW-1:0]      prod_ax;
  logic [FW-1:0]      fsum;
  logic [SB-1:0]      fnum;
  logic [PW-1:0]      hi_x, hi_y, sxe, sye, mn_x, mx_x, mn_y, mx_y;
  logic [DB-1:0]      ox, oy;
  logic [2*DB-1:0]    weight_c;
  logic               cont_x, cont_y;
  logic [AW-1:0]      rd_addr, lp_wr, lp_next;
  logic [PIX_W-1:0]   rd_data;
  logic               wr_en;
  logic [DB-1:0]      cx, cy;
  logic               fe_c;
  logic [DXI-1:0]     col_next;
  logic [DYI-1:0]     row_next;
  logic [DVW:0]       rem_sh;
  logic               div_ge;
  logic [WB-1:0]      wx0, wy0;
  logic [AB-1:0]      acc_add [CH_COUNT];
  logic [CH_W-1:0]    t0_c [CH_COUNT];
  logic [CH_W-1:0]    t1_c [CH_COUNT];
  logic [CH_W-1:0]    v_c [CH_COUNT];

  always_comb begin
    sw_c = SB'((src_w_r == '0) ? 32'd1 :
               ((32'(src_w_r) > 32'(MAX_SRC_W)) ? 32'(MAX_SRC_W) : 32'(src_w_r)));
    sh_c = SB'((src_h_r == '0) ? 32'd1 :
               ((32'(src_h_r) > 32'(MAX_SRC_H)) ? 32'(MAX_SRC_H) : 32'(src_h_r)));
    dw_c = DB'((dst_w_r == '0) ? 32'd1 :
               ((32'(dst_w_r) > 32'(MAX_DST_W)) ? 32'(MAX_DST_W) : 32'(dst_w_r)));
    dh_c = DB'((dst_h_r == '0) ? 32'd1 :
               ((32'(dst_h_r) > 32'(MAX_DST_H)) ? 32'(MAX_DST_H) : 32'(dst_h_r)));
    cc_c = (cc_r == '0) ? CC_W'(1) :
           ((32'(cc_r) > 32'(CH_COUNT)) ? CC_W'(CH_COUNT) : cc_r);
    total_c   = TB'(sw_c) * TB'(sh_c);
    area_mode = (32'(sw_c) >= 32'(dw_c)) && (32'(sh_c) >= 32'(dh_c));
  end

  // Load and fetch positions, wrapped against the current frame sizes.
  always_comb begin
    lp_wr   = (32'(lpos_r) >= 32'(total_c)) ? '0 : lpos_r;
    lp_next = (32'(lp_wr) + 32'd1 >= 32'(total_c)) ? '0 : AW'(32'(lp_wr) + 32'd1);
    cx      = (32'(col_r) >= 32'(dw_c)) ? '0 : DB'(col_r);
    cy      = (32'(row_r) >= 32'(dh_c)) ? '0 : DB'(row_r);
    fe_c    = (32'(cx) + 32'd1 == 32'(dw_c)) && (32'(cy) + 32'd1 == 32'(dh_c));
    if (32'(cx) + 32'd1 >= 32'(dw_c)) begin
      col_next = '0;
      row_next = (32'(cy) + 32'd1 >= 32'(dh_c)) ? '0 : DYI'(32'(cy) + 32'd1);
    end else begin
      col_next = DXI'(32'(cx) + 32'd1);
      row_next = DYI'(cy);
    end
  end

  // Per-axis operands for the window origin and the bilinear weight.
  always_comb begin
    d_ax    = ax_r ? dy_r : dx_r;
    sn_ax   = ax_r ? sh_c : sw_c;
    dn_ax   = ax_r ? dh_c : dw_c;
    base_ax = ax_r ? base_y_r : base_x_r;
    prod_ax = PW'(d_ax) * PW'(sn_ax);
    q_s     = div_num_r[SB-1:0];
    fsum    = FW'(div_rem_r[DB-1:0]) + FW'(sn_ax);
    fnum    = (fsum > FW'(dn_ax)) ? SB'(fsum - FW'(dn_ax)) : '0;
  end

  // Overlap of the current source pixel with the destination pixel on each axis.
  always_comb begin
    hi_x     = lo_x_r + PW'(sw_c);
    hi_y     = lo_y_r + PW'(sh_c);
    sxe      = sxl_r + PW'(dw_c);
    sye      = syl_r + PW'(dh_c);
    mn_x     = (hi_x < sxe) ? hi_x : sxe;
    mx_x     = (lo_x_r > sxl_r) ? lo_x_r : sxl_r;
    mn_y     = (hi_y < sye) ? hi_y : sye;
    mx_y     = (lo_y_r > syl_r) ? lo_y_r : syl_r;
    ox       = DB'(mn_x - mx_x);
    oy       = DB'(mn_y - mx_y);
    weight_c = (2*DB)'(ox) * (2*DB)'(oy);
    cont_x   = (sxe < hi_x) && (32'(sx_r) + 32'd1 < 32'(sw_c));
    cont_y   = (sye < hi_y) && (32'(sy_r) + 32'd1 < 32'(sh_c));
  end

  always_comb begin
    nx      = (32'(base_x_r) + 32'd1 < 32'(sw_c)) ? SB'(base_x_r + SB'(1)) : base_x_r;
    ny      = (32'(base_y_r) + 32'd1 < 32'(sh_c)) ? SB'(base_y_r + SB'(1)) : base_y_r;
    row_sel = (state_r == S_BRD) ? (k_r[1] ? ny : base_y_r) : sy_r;
    col_sel = (state_r == S_BRD) ? (k_r[0] ? nx : base_x_r) : sx_r;
    rd_addr = AW'((2*SB)'(row_sel) * (2*SB)'(sw_c) + (2*SB)'(col_sel));
  end

  always_comb begin
    rem_sh = {div_rem_r, div_num_r[NW-1]};
    div_ge = rem_sh >= (DVW+1)'(div_den_r);
  end

  always_comb begin
    wx0 = WB'(WONE) - w1_x_r;
    wy0 = WB'(WONE) - w1_y_r;
    for (int c = 0; c < CH_COUNT; c++) begin
      acc_add[c] = acc_r[c] +
                   AB'((2*DB+CH_W)'(weight_r) * (2*DB+CH_W)'(rd_data[c*CH_W +: CH_W]));
      t0_c[c] = CH_W'((LW'(wx0) * LW'(p_r[0][c*CH_W +: CH_W]) +
                       LW'(w1_x_r) * LW'(p_r[1][c*CH_W +: CH_W]) + LW'(WHALF)) >> WBITS);
      t1_c[c] = CH_W'((LW'(wx0) * LW'(p_r[2][c*CH_W +: CH_W]) +
                       LW'(w1_x_r) * LW'(p_r[3][c*CH_W +: CH_W]) + LW'(WHALF)) >> WBITS);
      v_c[c]  = CH_W'((LW'(wy0) * LW'(t0_r[c]) + LW'(w1_y_r) * LW'(t1_r[c]) +
                       LW'(WHALF)) >> WBITS);
    end
  end

  assign wr_en = in_valid && in_ready && (in_action == ACT_LOAD);

  air_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_frame (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (lp_wr),
    .wr_data ({in_ch3, in_ch2, in_ch1, in_ch0}),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      lpos_r      <= '0;
      col_r       <= '0;
      row_r       <= '0;
      src_w_r     <= CFG_W'(RST_SIZE);
      src_h_r     <= CFG_W'(RST_SIZE);
      dst_w_r     <= CFG_W'(RST_SIZE);
      dst_h_r     <= CFG_W'(RST_SIZE);
      cc_r        <= CC_W'(RST_CHANNELS);
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SRC_W:    src_w_r <= cfg_data;
          REG_SRC_H:    src_h_r <= cfg_data;
          REG_DST_W:    dst_w_r <= cfg_data;
          REG_DST_H:    dst_h_r <= cfg_data;
          REG_CHANNELS: cc_r    <= cfg_data[CC_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_r && out_ready && (state_r != S_PUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            if (in_action == ACT_LOAD) begin
              lpos_r <= lp_next;
            end else begin
              dx_r    <= cx;
              dy_r    <= cy;
              fe_r    <= fe_c;
              col_r   <= col_next;
              row_r   <= row_next;
              ax_r    <= 1'b0;
              ch_r    <= '0;
              res_r   <= '{default: '0};
              state_r <= S_AQ;
            end
          end
        end
        S_AQ: begin
          div_num_r <= NW'(prod_ax);
          div_den_r <= DVW'(dn_ax);
          div_rem_r <= '0;
          div_cnt_r <= CNTW'(NW);
          ret_r     <= S_AR;
          if (ax_r) begin
            lo_y_r <= prod_ax;
          end else begin
            lo_x_r <= prod_ax;
          end
          state_r <= S_DIV;
        end
        S_DIV: begin
          div_num_r <= {div_num_r[NW-2:0], div_ge};
          div_rem_r <= div_ge ? DVW'(rem_sh - (DVW+1)'(div_den_r)) : DVW'(rem_sh);
          div_cnt_r <= div_cnt_r - CNTW'(1);
          if (div_cnt_r == CNTW'(1)) begin
            state_r <= ret_r;
          end
        end
        S_AR: begin
          if (ax_r) begin
            base_y_r <= q_s;
          end else begin
            base_x_r <= q_s;
          end
          if (area_mode) begin
            if (!ax_r) begin
              sl0_x_r <= lo_x_r - PW'(div_rem_r);
              ax_r    <= 1'b1;
              state_r <= S_AQ;
            end else begin
              sy_r    <= q_s;
              syl_r   <= lo_y_r - PW'(div_rem_r);
              sx_r    <= base_x_r;
              sxl_r   <= sl0_x_r;
              acc_r   <= '{default: '0};
              state_r <= S_PA;
            end
          end else begin
            div_num_r <= NW'({fnum, {(WBITS+1){1'b0}}}) + NW'(sn_ax);
            div_den_r <= DVW'({sn_ax, 1'b0});
            div_rem_r <= '0;
            div_cnt_r <= CNTW'(NW);
            ret_r     <= S_AW;
            state_r   <= S_DIV;
          end
        end
        S_AW: begin
          if (32'(base_ax) + 32'd1 >= 32'(sn_ax)) begin
            if (ax_r) begin
              base_y_r <= (32'(sn_ax) >= 32'd2) ? SB'(sn_ax - SB'(2)) : '0;
              w1_y_r   <= WB'(WONE);
            end else begin
              base_x_r <= (32'(sn_ax) >= 32'd2) ? SB'(sn_ax - SB'(2)) : '0;
              w1_x_r   <= WB'(WONE);
            end
          end else begin
            if (ax_r) begin
              w1_y_r <= div_num_r[WB-1:0];
            end else begin
              w1_x_r <= div_num_r[WB-1:0];
            end
          end
          if (!ax_r) begin
            ax_r    <= 1'b1;
            state_r <= S_AQ;
          end else begin
            k_r     <= '0;
            state_r <= S_BRD;
          end
        end
        S_PA: begin
          weight_r <= weight_c;
          state_r  <= S_PB;
        end
        S_PB: begin
          acc_r <= acc_add;
          if (cont_x) begin
            sx_r    <= SB'(sx_r + SB'(1));
            sxl_r   <= sxe;
            state_r <= S_PA;
          end else if (cont_y) begin
            sx_r    <= base_x_r;
            sxl_r   <= sl0_x_r;
            sy_r    <= SB'(sy_r + SB'(1));
            syl_r   <= sye;
            state_r <= S_PA;
          end else begin
            ch_r    <= '0;
            state_r <= S_FQ;
          end
        end
        S_FQ: begin
          div_num_r <= NW'({acc_r[ch_r], 1'b0}) + NW'(total_c);
          div_den_r <= DVW'({total_c, 1'b0});
          div_rem_r <= '0;
          div_cnt_r <= CNTW'(NW);
          ret_r     <= S_FR;
          state_r   <= S_DIV;
        end
        S_FR: begin
          res_r[ch_r] <= (div_num_r > NW'(BYTE_MAX)) ? CH_W'(BYTE_MAX) : div_num_r[CH_W-1:0];
          if (32'(ch_r) + 32'd1 < 32'(cc_c)) begin
            ch_r    <= ch_r + 2'd1;
            state_r <= S_FQ;
          end else begin
            state_r <= S_PUT;
          end
        end
        S_BRD: begin
          if (k_r != '0) begin
            p_r[2'(k_r - KW'(1))] <= rd_data;
          end
          if (k_r == KW'(NEIGHBOURS)) begin
            state_r <= S_BT;
          end else begin
            k_r <= k_r + KW'(1);
          end
        end
        S_BT: begin
          t0_r    <= t0_c;
          t1_r    <= t1_c;
          state_r <= S_BV;
        end
        S_BV: begin
          for (int c = 0; c < CH_COUNT; c++) begin
            if (32'(c) < 32'(cc_c)) begin
              res_r[c] <= v_c[c];
            end
          end
          state_r <= S_PUT;
        end
        S_PUT: begin
          if (!out_valid_r || out_ready) begin
            out_r       <= res_r;
            out_fe_r    <= fe_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_ch0       = out_r[0];
  assign out_ch1       = out_r[1];
  assign out_ch2       = out_r[2];
  assign out_ch3       = out_r[3];
  assign out_frame_end = out_fe_r;

endmodule

// ===== hw/rtl/air_checker.sv =====
// Port-level checker for the image resizer and its bind statement.
`include "area_image_resize_defines.svh"

module air_checker (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     in_action,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [air_pkg::CH_W-1:0] out_ch0,
  input logic [air_pkg::CH_W-1:0] out_ch1,
  input logic [air_pkg::CH_W-1:0] out_ch2,
  input logic [air_pkg::CH_W-1:0] out_ch3,
  input logic                     out_frame_end
);

  import air_pkg::*;

  logic load_beat, fetch_beat;

  assign load_beat  = in_valid && in_ready && (in_action == ACT_LOAD);
  assign fetch_beat = in_valid && in_ready && (in_action == ACT_FETCH);

  `AIR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_ch0) && $stable(out_ch1) && $stable(out_ch2) && $stable(out_ch3) && $stable(out_frame_end), "result beat changed while stalled")
  `AIR_ASSERT_NEXT_ALWAYS(a_reset_quiet, !rst_n, !out_valid, "result beat shown after reset")
  `AIR_ASSERT_NEXT(a_load_silent, load_beat && !out_valid, !out_valid, "load beat produced a result")
  `AIR_ASSERT_SAME(a_fetch_busy, $past(fetch_beat) && $past(rst_n), !in_ready, "input taken while a fetch is in progress")

endmodule

bind area_image_resize air_checker u_air_checker (.*);

// ===== verif/area_image_resize_tb.sv =====
// Self-checking testbench of the area and bilinear image resizer, with its own pixel predictor.
module area_image_resize_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import air_pkg::*;

  typedef struct packed {
    logic [CH_W-1:0] ch0;
    logic [CH_W-1:0] ch1;
    logic [CH_W-1:0] ch2;
    logic [CH_W-1:0] ch3;
    logic            frame_end;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_action = ACT_LOAD;
  logic [CH_W-1:0] in_ch0 = '0, in_ch1 = '0, in_ch2 = '0, in_ch3 = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [CH_W-1:0] out_ch0, out_ch1, out_ch2, out_ch3;
  logic out_frame_end;
  logic cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = REG_SRC_W;
  logic [CFG_W-1:0] cfg_data = '0;

  logic [CH_W-1:0] frame_mem [0:65535][0:CH_COUNT-1];
  int unsigned load_pos, col_pos, row_pos;
  int unsigned reg_sw, reg_sh, reg_dw, reg_dh, reg_cc;
  pixel_t expected_pixels [$];
  int mismatches = 0;
  int items_sent = 0;
  bit quiet = 1'b0;
  int stall_pct = 20;
  int stall_left = 0;

  area_image_resize u_dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int unsigned clamp_size(int unsigned v);
    return v < 1 ? 1 : (v > 256 ? 256 : v);
  endfunction

  function automatic longint unsigned span_overlap(longint unsigned d, longint unsigned s,
                                                   longint unsigned sn, longint unsigned dn);
    longint unsigned lo, hi;
    lo = d * sn;
    hi = (d + 1) * sn;
    if (s * dn > lo) lo = s * dn;
    if ((s + 1) * dn < hi) hi = (s + 1) * dn;
    return hi > lo ? hi - lo : 0;
  endfunction

  function automatic void blend_axis(int unsigned d, int unsigned sn, int unsigned dn,
                                     output int unsigned base, output int unsigned w1);
    longint unsigned s, fnum;
    longint num;
    s = (longint'(d) * sn) / dn;
    num = longint'((longint'(d) + 1) * sn) - longint'((s + 1) * dn);
    fnum = num > 0 ? longint'(num) % sn : 0;
    w1 = (fnum * 2 * WONE + sn) / (2 * longint'(sn));
    if (s + 1 >= sn) begin
      s = sn >= 2 ? sn - 2 : 0;
      w1 = WONE;
    end
    base = s;
  endfunction

  function automatic void predict_beat(logic act, logic [CH_W-1:0] c0, logic [CH_W-1:0] c1,
                                       logic [CH_W-1:0] c2, logic [CH_W-1:0] c3);
    int unsigned sw, sh, dw, dh, cc, total, dx, dy;
    int unsigned x0, x1, y0, y1, bx, by, wx1, wy1, nx, ny, t0, t1, v;
    longint unsigned sum, den, oy;
    logic [CH_W-1:0] res [0:CH_COUNT-1];
    pixel_t px;
    sw = clamp_size(reg_sw);
    sh = clamp_size(reg_sh);
    dw = clamp_size(reg_dw);
    dh = clamp_size(reg_dh);
    cc = reg_cc < 1 ? 1 : (reg_cc > 4 ? 4 : reg_cc);
    total = sw * sh;
    if (act == ACT_LOAD) begin
      if (load_pos >= total) load_pos = 0;
      frame_mem[load_pos][0] = c0;
      frame_mem[load_pos][1] = c1;
      frame_mem[load_pos][2] = c2;
      frame_mem[load_pos][3] = c3;
      load_pos++;
      if (load_pos >= total) load_pos = 0;
      return;
    end
    if (col_pos >= dw) col_pos = 0;
    if (row_pos >= dh) row_pos = 0;
    dx = col_pos;
    dy = row_pos;
    for (int c = 0; c < CH_COUNT; c++) res[c] = '0;
    if (sw >= dw && sh >= dh) begin
      x0 = (longint'(dx) * sw) / dw;
      x1 = ((longint'(dx) + 1) * sw - 1) / dw;
      y0 = (longint'(dy) * sh) / dh;
      y1 = ((longint'(dy) + 1) * sh - 1) / dh;
      den = longint'(sw) * sh;
      for (int c = 0; c < cc; c++) begin
        sum = 0;
        for (int unsigned sy = y0; sy <= y1 && sy < sh; sy++) begin
          oy = span_overlap(dy, sy, sh, dh);
          for (int unsigned sx = x0; sx <= x1 && sx < sw; sx++)
            sum += span_overlap(dx, sx, sw, dw) * oy * frame_mem[sy * sw + sx][c];
        end
        sum = (2 * sum + den) / (2 * den);
        res[c] = sum > BYTE_MAX ? BYTE_MAX : sum[CH_W-1:0];
      end
    end else begin
      blend_axis(dx, sw, dw, bx, wx1);
      blend_axis(dy, sh, dh, by, wy1);
      nx = bx + 1 < sw ? bx + 1 : bx;
      ny = by + 1 < sh ? by + 1 : by;
      for (int c = 0; c < cc; c++) begin
        t0 = ((WONE - wx1) * frame_mem[by * sw + bx][c] + wx1 * frame_mem[by * sw + nx][c]
              + WHALF) >> WBITS;
        t1 = ((WONE - wx1) * frame_mem[ny * sw + bx][c] + wx1 * frame_mem[ny * sw + nx][c]
              + WHALF) >> WBITS;
        v = ((WONE - wy1) * t0 + wy1 * t1 + WHALF) >> WBITS;
        res[c] = v > BYTE_MAX ? BYTE_MAX : v[CH_W-1:0];
      end
    end
    px.ch0 = res[0];
    px.ch1 = res[1];
    px.ch2 = res[2];
    px.ch3 = res[3];
    px.frame_end = (dx + 1 == dw && dy + 1 == dh);
    expected_pixels.push_back(px);
    col_pos++;
    if (col_pos >= dw) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= dh) row_pos = 0;
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_beat(logic act, logic [CH_W-1:0] c0, logic [CH_W-1:0] c1,
                           logic [CH_W-1:0] c2, logic [CH_W-1:0] c3);
    int gap;
    in_valid <= 1'b1;
    in_action <= act;
    in_ch0 <= c0;
    in_ch1 <= c1;
    in_ch2 <= c2;
    in_ch3 <= c3;
    do @(posedge clk); while (!in_ready);
    predict_beat(act, c0, c1, c2, c3);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random(logic act);
    send_beat(act, CH_W'($urandom), CH_W'($urandom), CH_W'($urandom), CH_W'($urandom));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic configure(int unsigned sw, int unsigned sh, int unsigned dw, int unsigned dh,
                           int unsigned cc);
    int unsigned vals [5];
    logic [IDX_W-1:0] idx [5];
    vals = '{sw, sh, dw, dh, cc};
    idx = '{REG_SRC_W, REG_SRC_H, REG_DST_W, REG_DST_H, REG_CHANNELS};
    wait_idle();
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= vals[i][CFG_W-1:0];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    reg_sw = sw & 9'h1ff;
    reg_sh = sh & 9'h1ff;
    reg_dw = dw & 9'h1ff;
    reg_dh = dh & 9'h1ff;
    reg_cc = cc & 3'h7;
  endtask

  task automatic fill_frame();
    int unsigned total;
    total = clamp_size(reg_sw) * clamp_size(reg_sh);
    repeat (total) send_random(ACT_LOAD);
  endtask

  task automatic test_identity_extremes();
    configure(4, 3, 4, 3, 4);
    send_beat(ACT_LOAD, 8'h00, 8'hff, 8'h00, 8'hff);
    send_beat(ACT_LOAD, 8'hff, 8'h00, 8'hff, 8'h00);
    repeat (10) send_random(ACT_LOAD);
    repeat (12) send_random(ACT_FETCH);
  endtask

  task automatic test_area_downscale();
    configure(7, 5, 3, 2, 3);
    fill_frame();
    repeat (6) send_random(ACT_FETCH);
  endtask

  task automatic test_bilinear_upscale();
    configure(3, 2, 8, 5, 2);
    fill_frame();
    repeat (14) send_random(ACT_FETCH);
    configure(1, 1, 2, 3, 1);
    fill_frame();
    repeat (6) send_random(ACT_FETCH);
    configure(1, 4, 3, 2, 4);
    fill_frame();
    repeat (6) send_random(ACT_FETCH);
  endtask

  task automatic test_out_of_range_registers();
    configure(0, 300, 0, 511, 0);
    fill_frame();
    repeat (5) send_random(ACT_FETCH);
    configure(2, 2, 3, 3, 7);
    fill_frame();
    repeat (4) send_random(ACT_FETCH);
  endtask

  task automatic test_widest_window();
    configure(256, 1, 1, 1, 4);
    quiet = 1'b1;
    fill_frame();
    quiet = 1'b0;
    repeat (3) send_random(ACT_FETCH);
    configure(256, 1, 256, 1, 1);
    repeat (4) send_random(ACT_FETCH);
  endtask

  task automatic test_random_frames();
    int unsigned mix;
    while (items_sent < 650) begin
      configure($urandom_range(1, 10), $urandom_range(1, 8), $urandom_range(1, 12),
                $urandom_range(1, 10), $urandom_range(0, 7));
      quiet = ($urandom_range(0, 3) == 0);
      stall_pct = quiet ? 0 : $urandom_range(5, 50);
      if ($urandom_range(0, 9) != 0) fill_frame();
      else repeat (clamp_size(reg_sw) * clamp_size(reg_sh) + $urandom_range(1, 5))
        send_random(ACT_LOAD);
      mix = $urandom_range(15, 45);
      repeat (mix) send_random($urandom_range(0, 99) < 75 ? ACT_FETCH : ACT_LOAD);
    end
    quiet = 1'b0;
  endtask

  always @(posedge clk) begin
    int r;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (!quiet && r < 3) begin
        stall_left <= $urandom_range(10, 40);
        out_ready <= 1'b0;
      end else begin
        out_ready <= (quiet || r >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    pixel_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_ch0, out_ch1, out_ch2, out_ch3, out_frame_end};
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result beat: %p", got);
      end else begin
        want = expected_pixels.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("Pixel mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_identity_extremes();
    test_area_downscale();
    test_bilinear_upscale();
    test_out_of_range_registers();
    test_widest_window();
    test_random_frames();
    wait_idle();
    repeat (50) @(posedge clk);
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("area_image_resize_tb passed");
    end else begin
      $display("area_image_resize_tb failed");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("area_image_resize_tb failed");
    $finish;
  end

endmodule
